// ===== design/pdf_pkg.sv =====
// Shared types and constants for the PES packet deframer.
`timescale 1ns / 1ps
package pdf_pkg;

   // Parser phases
   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_DISCARD = 2'd2;

   localparam int HDR_BYTES = 6;
   localparam int HDR_STORE = 5;   // last header byte is taken straight from the input
   localparam logic [2:0] HDR_LAST_IDX = 3'd5;

   localparam logic [7:0] START_BYTE0 = 8'h00;
   localparam logic [7:0] START_BYTE1 = 8'h00;
   localparam logic [7:0] START_BYTE2 = 8'h01;

   localparam logic [7:0]  PES_SID_RESET = 8'hbd;
   localparam logic [15:0] MAX_LEN_RESET = 16'h4000;

   // Register select (paddr[2])
   localparam logic CSR_PES_SID = 1'b0;
   localparam logic CSR_MAX_LEN = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // One queued job: a single payload byte, or a whole header to expand
   typedef struct packed {
      logic            is_hdr;
      logic            last;
      logic [5:0][7:0] bytes;
   } pdf_cmd_type;

endpackage

// ===== design/pes_packet_deframer_core.sv =====
// PES packet deframer top level: register port, front end, job queue, output sequencer.
// Path: an accepted item is written into the job queue, then loaded into the output
// register that drives rsp_tvalid; with the queue empty and rsp_tready high, nothing stalls it.
// Throughput: one item per cycle while the job queue is not full; a completed header yields
// six output items, the four-entry job queue takes the next three payload items, then input
// stalls. Reset (synchronous, active high): parser to header collection,
// counters cleared, queue and output emptied, stream id to 0xBD, max length to 16384.
`timescale 1ns / 1ps
module pes_packet_deframer_core import pdf_pkg::*; #(
   parameter int BUFFER_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] packet_byte
   output logic        rsp_tuser,    // [0] packet_first
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]  pes_sid_ff, pes_sid_in;
   logic [15:0] max_len_ff, max_len_in;
   logic        csr_wr;

   logic        push, q_full, pop, head_valid;
   pdf_cmd_type push_cmd, head_cmd;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      pes_sid_in = pes_sid_ff;
      max_len_in = max_len_ff;
      csr_prdata = '0;
      case (csr_paddr[2])
         CSR_PES_SID: begin
            csr_prdata = {24'd0, pes_sid_ff};
            if (csr_wr) pes_sid_in = csr_pwdata[7:0];
         end
         CSR_MAX_LEN: begin
            csr_prdata = {16'd0, max_len_ff};
            if (csr_wr) max_len_in = csr_pwdata[15:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pes_sid_ff <= PES_SID_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         pes_sid_ff <= pes_sid_in;
         max_len_ff <= max_len_in;
      end
   end

   pdf_front #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .in_end    (req_tlast),
      .in_ready  (req_tready),
      .pes_sid   (pes_sid_ff),
      .max_len   (max_len_ff),
      .q_full    (q_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   pdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   pdf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_data   (rsp_tdata),
      .out_first  (rsp_tuser),
      .out_last   (rsp_tlast),
      .out_ready  (rsp_tready)
   );

endmodule

// ===== design/pdf_front.sv =====
// Front end: header collection, checks and packet tracking per input item.
`timescale 1ns / 1ps
module pdf_front import pdf_pkg::*; #(
   parameter int BUFFER_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [7:0]  in_data,
   input  logic        in_end,
   output logic        in_ready,
   input  logic [7:0]  pes_sid,
   input  logic [15:0] max_len,
   input  logic        q_full,
   output logic        push,
   output pdf_cmd_type push_cmd
);

   localparam int FILL_W = ($clog2(BUFFER_BYTES) + 1 > 17) ? $clog2(BUFFER_BYTES) + 1 : 17;
   localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(BUFFER_BYTES);

   logic [1:0]        phase_ff, phase_in;
   logic [2:0]        hcount_ff, hcount_in;
   logic [15:0]       rem_ff, rem_in;
   logic [15:0]       len_ff, len_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        hdr_ff [HDR_STORE];

   logic        accept;
   logic        hdr_wr;
   logic [2:0]  idx;
   logic [15:0] rem_dec;
   logic [15:0] len_w;
   logic        ok;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      phase_in  = phase_ff;
      hcount_in = hcount_ff;
      rem_in    = rem_ff;
      len_in    = len_ff;
      fill_in   = fill_ff;
      hdr_wr    = 1'b0;
      push      = 1'b0;
      push_cmd  = '0;
      idx       = (hcount_ff > HDR_LAST_IDX) ? 3'd0 : hcount_ff;
      rem_dec   = (rem_ff != 16'd0) ? rem_ff - 16'd1 : 16'd0;
      len_w     = {hdr_ff[4], in_data};
      ok        = hdr_ff[0] == START_BYTE0 && hdr_ff[1] == START_BYTE1 &&
                  hdr_ff[2] == START_BYTE2 && hdr_ff[3] == pes_sid &&
                  len_w != 16'd0 && len_w <= max_len;
      if (accept) begin
         if (fill_ff < FILL_LIMIT) begin
            fill_in = fill_ff + FILL_W'(1);
            if (phase_ff == PH_PAYLOAD) begin
               rem_in            = rem_dec;
               push              = 1'b1;
               push_cmd.last     = (rem_dec == 16'd0);
               push_cmd.bytes[0] = in_data;
               if (rem_dec == 16'd0) begin
                  phase_in  = PH_HEADER;
                  hcount_in = 3'd0;
               end
            end else if (phase_ff != PH_DISCARD) begin
               phase_in  = PH_HEADER;
               hcount_in = idx + 3'd1;
               hdr_wr    = (idx < HDR_LAST_IDX);
               if (idx == HDR_LAST_IDX) begin
                  hcount_in = 3'd0;
                  if (ok) begin
                     push            = 1'b1;
                     push_cmd.is_hdr = 1'b1;
                     for (int i = 0; i < HDR_STORE; i++) begin
                        push_cmd.bytes[i] = hdr_ff[i];
                     end
                     push_cmd.bytes[5] = in_data;
                     rem_in   = len_w;
                     len_in   = len_w;
                     phase_in = PH_PAYLOAD;
                  end else begin
                     phase_in = PH_DISCARD;
                  end
               end
            end
         end
         if (in_end) begin
            case (phase_in)
               PH_DISCARD: begin
                  phase_in  = PH_HEADER;
                  hcount_in = 3'd0;
                  fill_in   = '0;
               end
               PH_PAYLOAD: begin
                  // bytes carried over: header plus payload received so far
                  fill_in = FILL_W'(HDR_BYTES) + FILL_W'(len_in) - FILL_W'(rem_in);
               end
               default: begin
                  fill_in = FILL_W'(hcount_in);
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hcount_ff <= 3'd0;
         rem_ff    <= 16'd0;
         len_ff    <= 16'd0;
         fill_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         rem_ff    <= rem_in;
         len_ff    <= len_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_wr) begin
         hdr_ff[idx] <= in_data;
      end
   end

endmodule

// ===== design/pdf_queue.sv =====
// Short job queue between front end and output sequencer.
`timescale 1ns / 1ps
module pdf_queue import pdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  pdf_cmd_type push_cmd,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output pdf_cmd_type head_cmd
);

   pdf_cmd_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in    = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/pdf_back.sv =====
// Output sequencer: expands queued jobs into output items, one a cycle while the output is accepted.
`timescale 1ns / 1ps
module pdf_back import pdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  pdf_cmd_type head_cmd,
   output logic        pop,
   output logic        out_valid,
   output logic [7:0]  out_data,
   output logic        out_first,
   output logic        out_last,
   input  logic        out_ready
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       first_ff, first_in;
   logic       last_ff, last_in;
   logic [2:0] beat_ff, beat_in;
   logic       load;

   assign load = head_valid && (!valid_ff || out_ready);
   assign pop  = load && (!head_cmd.is_hdr || beat_ff == HDR_LAST_IDX);

   always_comb begin
      valid_in = valid_ff && !out_ready;
      data_in  = data_ff;
      first_in = first_ff;
      last_in  = last_ff;
      beat_in  = beat_ff;
      if (load) begin
         valid_in = 1'b1;
         if (head_cmd.is_hdr) begin
            data_in  = head_cmd.bytes[beat_ff];
            first_in = (beat_ff == 3'd0);
            last_in  = 1'b0;
            beat_in  = (beat_ff == HDR_LAST_IDX) ? 3'd0 : beat_ff + 3'd1;
         end else begin
            data_in  = head_cmd.bytes[0];
            first_in = 1'b0;
            last_in  = head_cmd.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      first_ff <= first_in;
      last_ff  <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_first = first_ff;
   assign out_last  = last_ff;

endmodule
